// ===== hdl/afu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package afu_pkg;

    localparam int COUNT_W     = 13;
    localparam int SAMPLE_W    = 16;
    localparam int STATUS_W    = 3;
    localparam int MODE_W      = 2;
    localparam int CFG_CH_W    = 4;
    localparam int CFG_LEN_W   = 12;
    localparam int PROD_W      = SAMPLE_W + 1 + COUNT_W;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;

    localparam int RING_SAMPLES_DEF = 4096;
    localparam int LAST_SAMPLES_DEF = 2048;
    localparam int MAX_CHANNELS_DEF = 8;

    localparam logic [CFG_CH_W-1:0]  NUM_CH_RST   = 4'd2;
    localparam logic [CFG_LEN_W-1:0] LAST_LEN_RST = 12'd2048;

    // register index, taken from paddr[2]
    localparam logic REG_NUM_CHANNELS   = 1'b0;
    localparam logic REG_LAST_CHUNK_LEN = 1'b1;

    typedef enum logic [MODE_W-1:0] {
        MODE_RESERVE = 2'd0,
        MODE_PUSH    = 2'd1,
        MODE_PERIOD  = 2'd2,
        MODE_PULL    = 2'd3
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_ACCEPTED = 3'd0,
        ST_REJECTED = 3'd1,
        ST_STORED   = 3'd2,
        ST_DROPPED  = 3'd3,
        ST_NORMAL   = 3'd4,
        ST_FADE     = 3'd5,
        ST_SILENCE  = 3'd6,
        ST_SAMPLE   = 3'd7
    } t_status;

    typedef enum logic [1:0] {
        PATH_NORMAL  = 2'd0,
        PATH_FADE    = 2'd1,
        PATH_SILENCE = 2'd2
    } t_path;

    typedef enum logic [2:0] {
        S_CLEAR = 3'd0,
        S_IDLE  = 3'd1,
        S_RING  = 3'd2,
        S_DIVF  = 3'd3,
        S_MUL   = 3'd4,
        S_DIVG  = 3'd5,
        S_OUT   = 3'd6
    } t_state;

    typedef struct packed {
        logic [MODE_W-1:0]          mode;
        logic [COUNT_W-1:0]         count;
        logic signed [SAMPLE_W-1:0] sample;
    } t_in;

    typedef struct packed {
        logic [STATUS_W-1:0]        status;
        logic signed [SAMPLE_W-1:0] sample_out;
        logic [COUNT_W-1:0]         fill;
    } t_out;

endpackage

`default_nettype wire

// ===== hdl/audio_fifo_underrun_fade.sv =====
// reserve, push, period start and silence pulls give their result beat in the cycle after acceptance;
// a normal pull passes S_RING (ring memory read) then S_OUT; a fade pull passes S_DIVF,
// S_MUL, S_DIVG (shared 1-bit-per-cycle divider runs twice: frame index, then gain), then S_OUT
// throughput: one item at a time, next item taken after the result beat leaves
// reset: counters, flags and period state clear at once; then a clearing pass
// zeroes every word of the last-chunk memory, no item is taken during it
`timescale 1ns / 1ps
`default_nettype none

module audio_fifo_underrun_fade #(
    parameter int RING_SAMPLES = afu_pkg::RING_SAMPLES_DEF,
    parameter int LAST_SAMPLES = afu_pkg::LAST_SAMPLES_DEF,
    parameter int MAX_CHANNELS = afu_pkg::MAX_CHANNELS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire afu_pkg::t_in                   i_in_data,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output afu_pkg::t_out                       o_out_data,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [afu_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [afu_pkg::APB_DATA_W-1:0] pwdata,
    output logic [afu_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready
);

    localparam int CountW  = afu_pkg::COUNT_W;
    localparam int SampleW = afu_pkg::SAMPLE_W;
    localparam int ProdW   = afu_pkg::PROD_W;
    localparam int DataW   = afu_pkg::APB_DATA_W;
    // counters run over twice the ring size so full and empty differ
    localparam int CW      = $clog2(2 * RING_SAMPLES);
    localparam int RAW     = $clog2(RING_SAMPLES);
    localparam int LAW     = $clog2(LAST_SAMPLES);
    localparam int CHW     = $clog2(MAX_CHANNELS + 1);
    localparam int SLW     = $clog2(LAST_SAMPLES + 1);
    localparam int PLW     = CountW + CHW;
    localparam int DIVW    = (ProdW > PLW) ? ProdW : PLW;
    localparam int STW     = $clog2(DIVW);

    // ---------------------------------------------------------------- config
    logic [afu_pkg::CFG_CH_W-1:0]  r_num_ch;
    logic [afu_pkg::CFG_LEN_W-1:0] r_last_len;
    logic                          cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_ch   <= afu_pkg::NUM_CH_RST;
            r_last_len <= afu_pkg::LAST_LEN_RST;
        end else if (cfg_wr) begin
            if (paddr[2] == afu_pkg::REG_NUM_CHANNELS) begin
                r_num_ch <= pwdata[afu_pkg::CFG_CH_W-1:0];
            end else begin
                r_last_len <= pwdata[afu_pkg::CFG_LEN_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == afu_pkg::REG_NUM_CHANNELS) begin
            prdata = DataW'(r_num_ch);
        end else begin
            prdata = DataW'(r_last_len);
        end
    end

    // effective channel count and store length after saturation
    logic [CHW-1:0] chans_eff;
    logic [SLW-1:0] store_len_eff;

    always_comb begin
        if (r_num_ch == '0) begin
            chans_eff = CHW'(1);
        end else if (32'(r_num_ch) > MAX_CHANNELS) begin
            chans_eff = CHW'(MAX_CHANNELS);
        end else begin
            chans_eff = CHW'(r_num_ch);
        end
        if (32'(r_last_len) > LAST_SAMPLES) begin
            store_len_eff = SLW'(LAST_SAMPLES);
        end else begin
            store_len_eff = SLW'(r_last_len);
        end
    end

    // ---------------------------------------------------------------- state
    afu_pkg::t_state r_state, n_state;

    logic [CW-1:0]         r_wc, n_wc, r_rc, n_rc;
    logic [CountW-1:0]     r_res_left, n_res_left;
    logic                  r_last_valid, n_last_valid;
    logic                  r_faded, n_faded;
    afu_pkg::t_path        r_path, n_path;
    logic [CountW-1:0]     r_pframes, n_pframes;
    logic [PLW-1:0]        r_pidx, n_pidx;
    logic [PLW-1:0]        r_plen, n_plen;
    logic [CHW-1:0]        r_pchans, n_pchans;
    logic                  r_save, n_save;
    logic [PLW-1:0]        r_cur_idx, n_cur_idx;
    afu_pkg::t_status      r_status, n_status;
    logic [SampleW-1:0]    r_res, n_res;
    logic                  r_have, n_have;
    logic                  r_src_ok, n_src_ok;
    logic                  r_neg, n_neg;
    logic [DIVW-1:0]       r_dq, n_dq;
    logic [CountW:0]       r_rem, n_rem;
    logic [CountW-1:0]     r_den, n_den;
    logic [STW-1:0]        r_step, n_step;
    logic [LAW-1:0]        r_clr, n_clr;

    // ---------------------------------------------------------------- memories
    logic [SampleW-1:0] ring_mem [RING_SAMPLES];
    logic [SampleW-1:0] last_mem [LAST_SAMPLES];
    logic [SampleW-1:0] r_ring_q, r_last_q;

    logic               ring_we, ring_re, last_we, last_re;
    logic [RAW-1:0]     ring_waddr, ring_raddr;
    logic [SampleW-1:0] ring_wdata, last_wdata;
    logic [LAW-1:0]     last_waddr, last_raddr;

    always_ff @(posedge i_clk) begin
        if (ring_we) begin
            ring_mem[ring_waddr] <= ring_wdata;
        end
        if (ring_re) begin
            r_ring_q <= ring_mem[ring_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (last_we) begin
            last_mem[last_waddr] <= last_wdata;
        end
        if (last_re) begin
            r_last_q <= last_mem[last_raddr];
        end
    end

    // ---------------------------------------------------------------- helpers
    logic [CW-1:0]  fill;
    logic [RAW-1:0] wslot, rslot;
    logic           in_acc;
    logic [CountW:0]   div_t;
    logic              div_ge;
    logic              div_done;
    logic signed [SampleW:0] src_ext;
    logic [SampleW:0]        src_mag;
    logic [CountW-1:0]       left;
    logic [PLW-1:0]          len_new;

    always_comb begin
        if (r_wc >= r_rc) begin
            fill = r_wc - r_rc;
        end else begin
            fill = CW'(32'(r_wc) + 2 * RING_SAMPLES - 32'(r_rc));
        end
        wslot = (32'(r_wc) >= RING_SAMPLES) ? RAW'(32'(r_wc) - RING_SAMPLES) : RAW'(r_wc);
        rslot = (32'(r_rc) >= RING_SAMPLES) ? RAW'(32'(r_rc) - RING_SAMPLES) : RAW'(r_rc);
    end

    // restoring divider, one quotient bit a cycle
    assign div_t    = {r_rem[CountW-1:0], r_dq[DIVW-1]};
    assign div_ge   = div_t >= {1'b0, r_den};
    assign div_done = (32'(r_step) == DIVW - 1);

    assign src_ext = r_src_ok ? (SampleW+1)'($signed(r_last_q)) : '0;
    assign src_mag = src_ext[SampleW] ? (SampleW+1)'(-src_ext) : (SampleW+1)'(src_ext);
    assign left    = r_pframes - r_dq[CountW-1:0];
    assign len_new = PLW'(i_in_data.count) * PLW'(chans_eff);

    assign o_in_stall  = (r_state != afu_pkg::S_IDLE);
    assign in_acc      = i_in_valid & !o_in_stall;
    assign o_out_valid = (r_state == afu_pkg::S_OUT);

    always_comb begin
        o_out_data.status     = r_status;
        o_out_data.sample_out = r_res;
        o_out_data.fill       = CountW'(fill);
    end

    function automatic logic [CW-1:0] cnt_next(input logic [CW-1:0] c);
        logic [CW-1:0] res;
        res = (32'(c) == 2 * RING_SAMPLES - 1) ? '0 : c + CW'(1);
        return res;
    endfunction

    // ---------------------------------------------------------------- next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            afu_pkg::S_CLEAR: begin
                if (32'(r_clr) == LAST_SAMPLES - 1) begin
                    n_state = afu_pkg::S_IDLE;
                end
            end
            afu_pkg::S_IDLE: begin
                if (in_acc) begin
                    if (i_in_data.mode == afu_pkg::MODE_PULL && r_pidx < r_plen &&
                        r_path == afu_pkg::PATH_NORMAL) begin
                        n_state = afu_pkg::S_RING;
                    end else if (i_in_data.mode == afu_pkg::MODE_PULL && r_pidx < r_plen &&
                                 r_path == afu_pkg::PATH_FADE) begin
                        n_state = afu_pkg::S_DIVF;
                    end else begin
                        n_state = afu_pkg::S_OUT;
                    end
                end
            end
            afu_pkg::S_RING: n_state = afu_pkg::S_OUT;
            afu_pkg::S_DIVF: if (div_done) n_state = afu_pkg::S_MUL;
            afu_pkg::S_MUL:  n_state = afu_pkg::S_DIVG;
            afu_pkg::S_DIVG: if (div_done) n_state = afu_pkg::S_OUT;
            afu_pkg::S_OUT:  if (!i_out_stall) n_state = afu_pkg::S_IDLE;
            default:         n_state = afu_pkg::S_IDLE;
        endcase
    end

    // ---------------------------------------------------------------- datapath
    always_comb begin
        n_wc         = r_wc;
        n_rc         = r_rc;
        n_res_left   = r_res_left;
        n_last_valid = r_last_valid;
        n_faded      = r_faded;
        n_path       = r_path;
        n_pframes    = r_pframes;
        n_pidx       = r_pidx;
        n_plen       = r_plen;
        n_pchans     = r_pchans;
        n_save       = r_save;
        n_cur_idx    = r_cur_idx;
        n_status     = r_status;
        n_res        = r_res;
        n_have       = r_have;
        n_src_ok     = r_src_ok;
        n_neg        = r_neg;
        n_dq         = r_dq;
        n_rem        = r_rem;
        n_den        = r_den;
        n_step       = r_step;
        n_clr        = r_clr;
        ring_we      = 1'b0;
        ring_waddr   = wslot;
        ring_wdata   = i_in_data.sample;
        ring_re      = 1'b0;
        ring_raddr   = rslot;
        last_we      = 1'b0;
        last_waddr   = r_clr;
        last_wdata   = '0;
        last_re      = 1'b0;
        last_raddr   = r_pidx[LAW-1:0];

        unique case (r_state)
            afu_pkg::S_CLEAR: begin
                last_we = 1'b1;
                n_clr   = r_clr + LAW'(1);
            end
            afu_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_res = '0;
                    unique case (afu_pkg::t_mode'(i_in_data.mode))
                        afu_pkg::MODE_RESERVE: begin
                            if (32'(i_in_data.count) + 32'(fill) <= RING_SAMPLES) begin
                                n_res_left = i_in_data.count;
                                n_status   = afu_pkg::ST_ACCEPTED;
                            end else begin
                                n_res_left = '0;
                                n_status   = afu_pkg::ST_REJECTED;
                            end
                        end
                        afu_pkg::MODE_PUSH: begin
                            if (r_res_left != '0 && 32'(fill) < RING_SAMPLES) begin
                                ring_we    = 1'b1;
                                n_wc       = cnt_next(r_wc);
                                n_res_left = r_res_left - CountW'(1);
                                n_status   = afu_pkg::ST_STORED;
                            end else begin
                                n_status = afu_pkg::ST_DROPPED;
                            end
                        end
                        afu_pkg::MODE_PERIOD: begin
                            n_pchans  = chans_eff;
                            n_pframes = i_in_data.count;
                            n_plen    = len_new;
                            n_pidx    = '0;
                            n_save    = 1'b0;
                            if (32'(fill) >= 32'(len_new)) begin
                                n_path  = afu_pkg::PATH_NORMAL;
                                n_faded = 1'b0;
                                if (32'(len_new) <= 32'(store_len_eff)) begin
                                    n_save       = 1'b1;
                                    n_last_valid = 1'b1;
                                end
                                n_status = afu_pkg::ST_NORMAL;
                            end else if (r_last_valid && !r_faded) begin
                                n_path   = afu_pkg::PATH_FADE;
                                n_faded  = 1'b1;
                                n_status = afu_pkg::ST_FADE;
                            end else begin
                                n_path   = afu_pkg::PATH_SILENCE;
                                n_status = afu_pkg::ST_SILENCE;
                            end
                        end
                        afu_pkg::MODE_PULL: begin
                            if (r_pidx >= r_plen) begin
                                n_status = afu_pkg::ST_SILENCE;
                            end else begin
                                n_status  = afu_pkg::ST_SAMPLE;
                                n_cur_idx = r_pidx;
                                n_pidx    = r_pidx + PLW'(1);
                                unique case (r_path)
                                    afu_pkg::PATH_NORMAL: begin
                                        n_have = (fill != '0);
                                        if (fill != '0) begin
                                            ring_re = 1'b1;
                                            n_rc    = cnt_next(r_rc);
                                        end
                                    end
                                    afu_pkg::PATH_FADE: begin
                                        // samples beyond the store length replay as zero
                                        n_src_ok = (32'(r_pidx) < 32'(store_len_eff)) &&
                                                   (32'(r_pidx) < LAST_SAMPLES);
                                        last_re  = 1'b1;
                                        n_dq     = DIVW'(r_pidx);
                                        n_rem    = '0;
                                        n_den    = CountW'(r_pchans);
                                        n_step   = '0;
                                    end
                                    default: ;
                                endcase
                            end
                        end
                        default: ;
                    endcase
                end
            end
            afu_pkg::S_RING: begin
                n_res = r_have ? r_ring_q : '0;
                if (r_save && 32'(r_cur_idx) < LAST_SAMPLES) begin
                    last_we    = 1'b1;
                    last_waddr = r_cur_idx[LAW-1:0];
                    last_wdata = r_have ? r_ring_q : '0;
                end
            end
            afu_pkg::S_DIVF, afu_pkg::S_DIVG: begin
                n_rem  = div_ge ? (div_t - {1'b0, r_den}) : div_t;
                n_dq   = {r_dq[DIVW-2:0], div_ge};
                n_step = r_step + STW'(1);
                if (r_state == afu_pkg::S_DIVG && div_done) begin
                    // quotient magnitude, sign restored (truncation toward zero)
                    n_res = r_neg ? SampleW'(-{r_dq[DIVW-2:0], div_ge})
                                  : SampleW'({r_dq[DIVW-2:0], div_ge});
                end
            end
            afu_pkg::S_MUL: begin
                n_neg  = src_ext[SampleW];
                n_dq   = DIVW'(src_mag * left);
                n_rem  = '0;
                n_den  = r_pframes;
                n_step = '0;
            end
            afu_pkg::S_OUT: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= afu_pkg::S_CLEAR;
            r_wc         <= '0;
            r_rc         <= '0;
            r_res_left   <= '0;
            r_last_valid <= 1'b0;
            r_faded      <= 1'b0;
            r_path       <= afu_pkg::PATH_SILENCE;
            r_pframes    <= '0;
            r_pidx       <= '0;
            r_plen       <= '0;
            r_pchans     <= '0;
            r_save       <= 1'b0;
            r_step       <= '0;
            r_clr        <= '0;
        end else begin
            r_state      <= n_state;
            r_wc         <= n_wc;
            r_rc         <= n_rc;
            r_res_left   <= n_res_left;
            r_last_valid <= n_last_valid;
            r_faded      <= n_faded;
            r_path       <= n_path;
            r_pframes    <= n_pframes;
            r_pidx       <= n_pidx;
            r_plen       <= n_plen;
            r_pchans     <= n_pchans;
            r_save       <= n_save;
            r_step       <= n_step;
            r_clr        <= n_clr;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_cur_idx <= n_cur_idx;
        r_status  <= n_status;
        r_res     <= n_res;
        r_have    <= n_have;
        r_src_ok  <= n_src_ok;
        r_neg     <= n_neg;
        r_dq      <= n_dq;
        r_rem     <= n_rem;
        r_den     <= n_den;
    end

    // ---------------------------------------------------------------- checks
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(fill) <= RING_SAMPLES)
        else $error("ring fill beyond capacity");

    a_no_ring_write_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ring_we |-> (32'(fill) < RING_SAMPLES))
        else $error("ring written while full");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state != afu_pkg::S_IDLE))
        else $error("accepted beat produced no work");

    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == afu_pkg::S_CLEAR) |-> (!o_out_valid && o_in_stall))
        else $error("activity during clearing pass");

endmodule

`default_nettype wire
